// File: design/xxh_pkg.sv
// Shared constants, command codes and datapath command struct for the XXH32 stream hash.
package xxh_pkg;

    localparam logic [31:0] PRIME1 = 32'd2654435761;
    localparam logic [31:0] PRIME2 = 32'd2246822519;
    localparam logic [31:0] PRIME3 = 32'd3266489917;
    localparam logic [31:0] PRIME4 = 32'd668265263;
    localparam logic [31:0] PRIME5 = 32'd374761393;

    localparam int WORD_W    = 32;
    localparam int CNT_W     = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam logic [CNT_W-1:0] FULL_COUNT = 3'd4;

    // multiplier operand sources
    localparam logic [1:0] MS_WORD = 2'd0;
    localparam logic [1:0] MS_ACC  = 2'd1;
    localparam logic [1:0] MS_BYTE = 2'd2;
    localparam logic [1:0] MS_XSH  = 2'd3;

    // multiplier constants
    localparam logic [2:0] K_P1 = 3'd0;
    localparam logic [2:0] K_P2 = 3'd1;
    localparam logic [2:0] K_P3 = 3'd2;
    localparam logic [2:0] K_P4 = 3'd3;
    localparam logic [2:0] K_P5 = 3'd4;

    // accumulator operations
    localparam logic [2:0] ACC_HOLD     = 3'd0;
    localparam logic [2:0] ACC_LANE_MIX = 3'd1;
    localparam logic [2:0] ACC_FOLD     = 3'd2;
    localparam logic [2:0] ACC_INIT     = 3'd3;
    localparam logic [2:0] ACC_ADD_LEN  = 3'd4;
    localparam logic [2:0] ACC_LOAD     = 3'd5;

    typedef struct packed {
        logic             accept;     // capture the input word and add its length
        logic             start;      // first item of a message: seed lanes
        logic [CNT_W-1:0] len_add;
        logic             buf_wr;
        logic [1:0]       buf_idx;
        logic             mul_en;
        logic [1:0]       mul_src;
        logic [2:0]       mul_k;
        logic [1:0]       word_idx;
        logic [1:0]       byte_idx;
        logic             xsh_13;     // 1: shift by 13, 0: shift by 15
        logic [2:0]       acc_op;
        logic             rot_byte;   // 1: fold rotate by 11, 0: by 17
        logic             had_stripe;
        logic             lane_wr;
        logic [1:0]       lane_idx;
        logic             out_load;
    } dp_cmd_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage

// File: design/xxh_ctrl.sv
// Sequencer for the XXH32 stream hash: handshakes, stripe rounds and finalisation steps.
module xxh_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [xxh_pkg::CNT_W-1:0]   s_byte_count,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output xxh_pkg::dp_cmd_t            cmd
);
    import xxh_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LMUL  = 4'd1;
    localparam logic [3:0] ST_LMIX  = 4'd2;
    localparam logic [3:0] ST_LMUL2 = 4'd3;
    localparam logic [3:0] ST_LWR   = 4'd4;
    localparam logic [3:0] ST_INIT  = 4'd5;
    localparam logic [3:0] ST_LEN   = 4'd6;
    localparam logic [3:0] ST_FMUL  = 4'd7;
    localparam logic [3:0] ST_FMIX  = 4'd8;
    localparam logic [3:0] ST_FMUL2 = 4'd9;
    localparam logic [3:0] ST_FLD   = 4'd10;
    localparam logic [3:0] ST_AV1   = 4'd11;
    localparam logic [3:0] ST_AV2   = 4'd12;
    localparam logic [3:0] ST_AV3   = 4'd13;
    localparam logic [3:0] ST_OUT   = 4'd14;

    logic [3:0]       state_reg, state_next;
    logic [1:0]       lane_idx_reg, lane_idx_next;
    logic [1:0]       loop_idx_reg, loop_idx_next;
    logic             byte_phase_reg, byte_phase_next;
    logic [1:0]       words_held_reg, words_held_next;
    logic             had_stripe_reg, had_stripe_next;
    logic             msg_open_reg, msg_open_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             m_valid_reg, m_valid_next;

    logic [CNT_W-1:0] n_eff;
    logic             out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign n_eff    = (!s_tlast || s_byte_count > FULL_COUNT) ? FULL_COUNT : s_byte_count;

    always_comb begin
        state_next      = state_reg;
        lane_idx_next   = lane_idx_reg;
        loop_idx_next   = loop_idx_reg;
        byte_phase_next = byte_phase_reg;
        words_held_next = words_held_reg;
        had_stripe_next = had_stripe_reg;
        msg_open_next   = msg_open_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        cmd            = '0;
        cmd.lane_idx   = lane_idx_reg;
        cmd.word_idx   = lane_idx_reg;
        cmd.byte_idx   = loop_idx_reg;
        cmd.had_stripe = had_stripe_reg;
        cmd.rot_byte   = byte_phase_reg;
        cmd.acc_op     = ACC_HOLD;
        cmd.mul_src    = MS_ACC;
        cmd.mul_k      = K_P1;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept    = 1'b1;
                    cmd.start     = !msg_open_reg;
                    cmd.len_add   = n_eff;
                    msg_open_next = 1'b1;
                    cnt_next      = n_eff;
                    last_next     = s_tlast;
                    if (n_eff == FULL_COUNT) begin
                        if (words_held_reg < 2'd3) begin
                            cmd.buf_wr      = 1'b1;
                            cmd.buf_idx     = words_held_reg;
                            words_held_next = words_held_reg + 2'd1;
                            state_next      = s_tlast ? ST_INIT : ST_IDLE;
                        end else begin
                            // stripe complete: run one round on every lane
                            words_held_next = 2'd0;
                            had_stripe_next = 1'b1;
                            lane_idx_next   = 2'd0;
                            state_next      = ST_LMUL;
                        end
                    end else begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_LMUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_WORD;
                cmd.mul_k   = K_P2;
                state_next  = ST_LMIX;
            end
            ST_LMIX: begin
                cmd.acc_op = ACC_LANE_MIX;
                state_next = ST_LMUL2;
            end
            ST_LMUL2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_ACC;
                cmd.mul_k   = K_P1;
                state_next  = ST_LWR;
            end
            ST_LWR: begin
                cmd.lane_wr = 1'b1;
                if (lane_idx_reg != 2'd3) begin
                    // overlap the next lane's first multiply with this write-back
                    cmd.mul_en    = 1'b1;
                    cmd.mul_src   = MS_WORD;
                    cmd.mul_k     = K_P2;
                    cmd.word_idx  = lane_idx_reg + 2'd1;
                    lane_idx_next = lane_idx_reg + 2'd1;
                    state_next    = ST_LMIX;
                end else begin
                    state_next = last_reg ? ST_INIT : ST_IDLE;
                end
            end
            ST_INIT: begin
                cmd.acc_op = ACC_INIT;
                state_next = ST_LEN;
            end
            ST_LEN: begin
                cmd.acc_op      = ACC_ADD_LEN;
                loop_idx_next   = 2'd0;
                byte_phase_next = 1'b0;
                state_next      = ST_FMUL;
            end
            ST_FMUL: begin
                if (!byte_phase_reg) begin
                    if (loop_idx_reg < words_held_reg) begin
                        cmd.mul_en   = 1'b1;
                        cmd.mul_src  = MS_WORD;
                        cmd.mul_k    = K_P3;
                        cmd.word_idx = loop_idx_reg;
                        state_next   = ST_FMIX;
                    end else begin
                        byte_phase_next = 1'b1;
                        loop_idx_next   = 2'd0;
                    end
                end else begin
                    if (cnt_reg != FULL_COUNT && {1'b0, loop_idx_reg} < cnt_reg) begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_src = MS_BYTE;
                        cmd.mul_k   = K_P5;
                        state_next  = ST_FMIX;
                    end else begin
                        state_next = ST_AV1;
                    end
                end
            end
            ST_FMIX: begin
                cmd.acc_op = ACC_FOLD;
                state_next = ST_FMUL2;
            end
            ST_FMUL2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_ACC;
                cmd.mul_k   = byte_phase_reg ? K_P1 : K_P4;
                state_next  = ST_FLD;
            end
            ST_FLD: begin
                cmd.acc_op    = ACC_LOAD;
                loop_idx_next = loop_idx_reg + 2'd1;
                state_next    = ST_FMUL;
            end
            ST_AV1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_XSH;
                cmd.xsh_13  = 1'b0;
                cmd.mul_k   = K_P2;
                state_next  = ST_AV2;
            end
            ST_AV2: begin
                cmd.acc_op = ACC_LOAD;
                state_next = ST_AV3;
            end
            ST_AV3: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_XSH;
                cmd.xsh_13  = 1'b1;
                cmd.mul_k   = K_P3;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.out_load    = 1'b1;
                    m_valid_next    = 1'b1;
                    words_held_next = 2'd0;
                    had_stripe_next = 1'b0;
                    msg_open_next   = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            lane_idx_reg   <= '0;
            loop_idx_reg   <= '0;
            byte_phase_reg <= 1'b0;
            words_held_reg <= '0;
            had_stripe_reg <= 1'b0;
            msg_open_reg   <= 1'b0;
            cnt_reg        <= '0;
            last_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            lane_idx_reg   <= lane_idx_next;
            loop_idx_reg   <= loop_idx_next;
            byte_phase_reg <= byte_phase_next;
            words_held_reg <= words_held_next;
            had_stripe_reg <= had_stripe_next;
            msg_open_reg   <= msg_open_next;
            cnt_reg        <= cnt_next;
            last_reg       <= last_next;
            m_valid_reg    <= m_valid_next;
        end
    end

endmodule

// File: design/xxh_datapath.sv
// Datapath for the XXH32 stream hash: seed register, lanes, stripe buffer, multiplier, accumulator.
module xxh_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [xxh_pkg::WORD_W-1:0]    cfg_wr_data,
    input  logic [xxh_pkg::WORD_W-1:0]    s_data_word,
    input  xxh_pkg::dp_cmd_t              cmd,
    output logic [xxh_pkg::WORD_W-1:0]    m_hash
);
    import xxh_pkg::*;

    logic [WORD_W-1:0] seed_cfg_reg;
    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] lane_reg [4];
    logic [WORD_W-1:0] buf_reg [3];
    logic [WORD_W-1:0] w_reg;
    logic [WORD_W-1:0] total_len_reg, total_len_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] hash_reg;

    logic [WORD_W-1:0] word_sel, byte_sel, xsh_val, mul_a, mul_k;
    logic [WORD_W-1:0] lane_sum, fold_sum, fold_rot, merge_val;

    always_comb begin
        unique case (cmd.word_idx)
            2'd0:    word_sel = buf_reg[0];
            2'd1:    word_sel = buf_reg[1];
            2'd2:    word_sel = buf_reg[2];
            default: word_sel = w_reg;
        endcase
    end

    assign byte_sel = {24'd0, w_reg[{cmd.byte_idx, 3'b000} +: 8]};
    assign xsh_val  = cmd.xsh_13 ? (acc_reg ^ (acc_reg >> 13)) : (acc_reg ^ (acc_reg >> 15));

    always_comb begin
        unique case (cmd.mul_src)
            MS_WORD: mul_a = word_sel;
            MS_ACC:  mul_a = acc_reg;
            MS_BYTE: mul_a = byte_sel;
            MS_XSH:  mul_a = xsh_val;
            default: mul_a = acc_reg;
        endcase
    end

    always_comb begin
        unique case (cmd.mul_k)
            K_P1:    mul_k = PRIME1;
            K_P2:    mul_k = PRIME2;
            K_P3:    mul_k = PRIME3;
            K_P4:    mul_k = PRIME4;
            K_P5:    mul_k = PRIME5;
            default: mul_k = PRIME1;
        endcase
    end

    // low word of the product only
    assign prod_next = cmd.mul_en ? mul_a * mul_k : prod_reg;

    assign lane_sum  = lane_reg[cmd.lane_idx] + prod_reg;
    assign fold_sum  = acc_reg + prod_reg;
    assign fold_rot  = cmd.rot_byte ? rotl32(fold_sum, 11) : rotl32(fold_sum, 17);
    assign merge_val = rotl32(lane_reg[0], 1) + rotl32(lane_reg[1], 7)
                     + rotl32(lane_reg[2], 12) + rotl32(lane_reg[3], 18);

    always_comb begin
        unique case (cmd.acc_op)
            ACC_HOLD:     acc_next = acc_reg;
            ACC_LANE_MIX: acc_next = rotl32(lane_sum, 13);
            ACC_FOLD:     acc_next = fold_rot;
            ACC_INIT:     acc_next = cmd.had_stripe ? merge_val : seed_reg + PRIME5;
            ACC_ADD_LEN:  acc_next = acc_reg + total_len_reg;
            ACC_LOAD:     acc_next = prod_reg;
            default:      acc_next = acc_reg;
        endcase
    end

    always_comb begin
        total_len_next = total_len_reg;
        if (cmd.accept) begin
            if (cmd.start) begin
                total_len_next = {{(WORD_W-CNT_W){1'b0}}, cmd.len_add};
            end else begin
                total_len_next = total_len_reg + {{(WORD_W-CNT_W){1'b0}}, cmd.len_add};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            seed_cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        total_len_reg <= total_len_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        if (cmd.accept) begin
            w_reg <= s_data_word;
        end
        if (cmd.buf_wr) begin
            buf_reg[cmd.buf_idx] <= s_data_word;
        end
        if (cmd.start) begin
            seed_reg    <= seed_cfg_reg;
            lane_reg[0] <= seed_cfg_reg + PRIME1 + PRIME2;
            lane_reg[1] <= seed_cfg_reg + PRIME2;
            lane_reg[2] <= seed_cfg_reg;
            lane_reg[3] <= seed_cfg_reg - PRIME1;
        end else if (cmd.lane_wr) begin
            lane_reg[cmd.lane_idx] <= prod_reg;
        end
        if (cmd.out_load) begin
            hash_reg <= prod_reg ^ (prod_reg >> 16);
        end
    end

    assign m_hash = hash_reg;

endmodule

// File: design/xxh32_stream_hash.sv
// Top level of the XXH32 stream hash: sequencer, datapath and checks.
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tdata: data_word[31:0], byte_count[34:32]; s_tlast
//  m_       out        m_tvalid/m_tready  m_tdata: hash_value[31:0]
//  cfg_     in         cfg_wr_en          cfg_wr_data: hash_seed
//
// A word that only fills the stripe buffer is taken straight from idle; the word that completes a stripe
// also runs the lane rounds through the single shared 32x32 multiplier before the next item is taken.
// Finalisation after the last item runs one multiply-fold pass per leftover word and per leftover byte.
// Reset (aresetn low, synchronous) clears the seed to zero and closes any open message.
// The next message may start while a finished hash waits in the output register; a stalled
// m_ side only blocks at the point where the following hash is ready to load.
module xxh32_stream_hash (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [xxh_pkg::WORD_W-1:0]        cfg_wr_data,   // hash_seed
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [xxh_pkg::S_TDATA_W-1:0]     s_tdata,       // data_word, byte_count
    input  logic                              s_tlast,       // last_word
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [xxh_pkg::M_TDATA_W-1:0]     m_tdata        // hash_value
);
    import xxh_pkg::*;

    dp_cmd_t           dp_cmd;
    logic [WORD_W-1:0] seed_data;
    logic [WORD_W-1:0] hash_word;

    assign seed_data = cfg_wr_data;

    xxh_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_byte_count (s_tdata[WORD_W +: CNT_W]),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cmd          (dp_cmd)
    );

    xxh_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (seed_data),
        .s_data_word (s_tdata[WORD_W-1:0]),
        .cmd         (dp_cmd),
        .m_hash      (hash_word)
    );

    assign m_tdata = M_TDATA_W'(hash_word);

`ifndef SYNTH
    // never overwrite a hash the sink has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("hash loaded over an untaken result");

    a_start_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.start |-> (s_tvalid && s_tready))
        else $error("lane seeding without an accepted item");

    // a non-final item never produces a result straight away
    a_no_result_mid_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tlast) |=> !$rose(m_tvalid))
        else $error("result raised after a non-final item");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the xxh32_stream_hash block: message streams, seed changes and back-pressure.
`timescale 1ns / 100ps

module tb_top;
    import xxh_pkg::*;

    localparam int QUIET_CYCLES = 48;   // stripe rounds plus the longest finalisation
    localparam int PHASE_ITEMS  = 175;

    // Hash predictor with its own message state and a queue of hashes still owed by the block.
    class xxh32_checker;
        logic [31:0] seed;
        logic [31:0] seed_used;
        logic [31:0] lane [4];
        logic [31:0] stripe [3];
        logic [31:0] msg_len;
        logic [1:0]  held;
        bit          had_stripe;
        bit          msg_open;
        logic [31:0] hash_due [$];
        int          failures;

        function new();
            seed = '0;
            msg_open = 1'b0;
            failures = 0;
        endfunction

        function logic [31:0] rol(input logic [31:0] x, input int unsigned r);
            logic [63:0] d;
            d = {x, x} << r;
            return d[63:32];
        endfunction

        function logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
            logic [31:0] p;
            p = a * b;
            return p;
        endfunction

        function logic [31:0] round_lane(input logic [31:0] acc, input logic [31:0] w);
            return mul(rol(acc + mul(w, PRIME2), 13), PRIME1);
        endfunction

        function void take_word(input logic [31:0] w);
            if (held < 2'd3) begin
                stripe[held] = w;
                held++;
            end else begin
                for (int i = 0; i < 3; i++)
                    lane[i] = round_lane(lane[i], stripe[i]);
                lane[3] = round_lane(lane[3], w);
                held = 2'd0;
                had_stripe = 1'b1;
            end
        endfunction

        function void absorb_item(input logic [31:0] w, input logic [CNT_W-1:0] cnt,
                                  input logic last);
            logic [CNT_W-1:0] n;
            logic [31:0]      h;
            if (!msg_open) begin
                seed_used = seed;
                lane[0] = seed + PRIME1 + PRIME2;
                lane[1] = seed + PRIME2;
                lane[2] = seed;
                lane[3] = seed - PRIME1;
                held = 2'd0;
                msg_len = '0;
                had_stripe = 1'b0;
                msg_open = 1'b1;
            end
            // short counts only count on the closing item; oversized counts saturate
            n = (cnt > FULL_COUNT || !last) ? FULL_COUNT : cnt;
            msg_len += n;
            if (n == FULL_COUNT)
                take_word(w);
            if (!last)
                return;
            if (had_stripe)
                h = rol(lane[0], 1) + rol(lane[1], 7) + rol(lane[2], 12) + rol(lane[3], 18);
            else
                h = seed_used + PRIME5;
            h += msg_len;
            for (int i = 0; i < held; i++)
                h = mul(rol(h + mul(stripe[i], PRIME3), 17), PRIME4);
            if (n < FULL_COUNT) begin
                for (int i = 0; i < n; i++)
                    h = mul(rol(h + mul({24'd0, w[8*i +: 8]}, PRIME5), 11), PRIME1);
            end
            h ^= h >> 15;
            h = mul(h, PRIME2);
            h ^= h >> 13;
            h = mul(h, PRIME3);
            h ^= h >> 16;
            hash_due.push_back(h);
            msg_open = 1'b0;
        endfunction

        function void check_hash(input logic [31:0] got);
            logic [31:0] want;
            if (hash_due.size() == 0) begin
                $error("hash_value: no hash expected, got %h", got);
                failures++;
                return;
            end
            want = hash_due.pop_front();
            if (got !== want) begin
                $error("hash_value: expected %h, got %h", want, got);
                failures++;
            end
        endfunction

        function int pending();
            return hash_due.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [31:0]          cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;

    xxh32_checker sb = new();

    xxh32_stream_hash DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.absorb_item(s_tdata[31:0], s_tdata[34:32], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_hash(m_tdata);
        end
    end

    // Hold the item until the block takes it; valid stays high for a following item.
    task automatic send_item(input logic [31:0] w, input logic [CNT_W-1:0] cnt,
                             input logic last);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, cnt, w};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sb.seed = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(19))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed messages; now and then a short or oversized count mid-message.
    task automatic send_message();
        int r;
        int words;
        logic [CNT_W-1:0] cnt;
        r = $urandom_range(99);
        if (r < 5)
            words = 1;
        else if (r < 80)
            words = $urandom_range(12, 1);
        else
            words = $urandom_range(40, 13);
        if (r < 5) begin
            send_item(pick_word(), 3'd0, 1'b1);
        end else begin
            for (int i = 0; i < words - 1; i++) begin
                cnt = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : FULL_COUNT;
                send_item(pick_word(), cnt, 1'b0);
            end
            send_item(pick_word(), 3'($urandom_range(7)), 1'b1);
        end
    endtask

    task automatic run_phase(input logic [31:0] seed_val, input int idle_pct,
                             input int stall_pct);
        int target;
        write_seed(seed_val);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target)
            send_message();
        drop_valid();
    endtask

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // seed at its reset value: empty message and one-word messages
        send_item(32'h0000_0000, 3'd0, 1'b1);
        send_item(32'hFFFF_FFFF, FULL_COUNT, 1'b1);
        send_item(32'hFFFF_FFFF, 3'd1, 1'b1);
        send_item(32'h1234_5678, 3'd3, 1'b1);
        send_item(32'h0000_0000, 3'd7, 1'b1);
        // one stripe with odd counts mid-message, three leftover words, partial tail
        send_item(32'hFFFF_FFFF, FULL_COUNT, 1'b0);
        send_item(32'h0000_0000, 3'd1, 1'b0);
        send_item(32'hA5A5_5A5A, 3'd0, 1'b0);
        send_item(32'h8000_0001, 3'd7, 1'b0);
        send_item(32'h0123_4567, 3'd2, 1'b0);
        send_item(32'h89AB_CDEF, 3'd5, 1'b0);
        send_item(32'hFFFF_FFFF, FULL_COUNT, 1'b0);
        send_item(32'hDEAD_BEEF, 3'd3, 1'b1);
        // stripe completed by the closing item
        send_item(32'h0000_0001, FULL_COUNT, 1'b0);
        send_item(32'h0000_0002, FULL_COUNT, 1'b0);
        send_item(32'h0000_0003, FULL_COUNT, 1'b0);
        send_item(32'hFFFF_FFFF, 3'd6, 1'b1);
        drop_valid();

        write_seed(32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 3'd0, 1'b1);
        send_item(32'hFFFF_FFFF, FULL_COUNT, 1'b1);
        drop_valid();
        write_seed(32'h8000_0000);
        send_item(32'h7FFF_FFFF, FULL_COUNT, 1'b0);
        send_item(32'hC3C3_3C3C, 3'd2, 1'b1);
        drop_valid();

        run_phase(32'h0000_0000, 0, 0);
        run_phase(32'hFFFF_FFFF, 85, 0);
        run_phase($urandom, 0, 85);
        run_phase($urandom, 6, 6);

        wait_idle();
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
